[rtl/rgbhsv_pkg.sv]
`timescale 1ns / 1ps
// rgbhsv_pkg: widths, constants and pipeline word types for the rgb to hsv converter
// no dependencies; used by the interfaces, the divider stage, the top level and the checker

package rgbhsv_pkg;

   // fixed field widths of the pixel and result words
   localparam int RGB_BITS = 8;
   localparam int HUE_BITS = 15;
   localparam int SAT_BITS = 8;
   localparam int VAL_BITS = 8;

   // arithmetic configuration
   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 6;

   localparam longint CHAN_MAX    = (64'd1 << CHANNEL_BITS) - 64'd1;
   localparam longint SIXTH       = 64'd60 << HUE_FRAC_BITS;
   localparam longint FULL_CIRCLE = 64'd360 << HUE_FRAC_BITS;

   // quotient bits needed by the hue division (quotient reaches sixth)
   localparam int Q_BITS    = $clog2(SIXTH + 1);
   // one quotient bit per divider stage, wide enough for both divisions
   localparam int DIV_STEPS = (Q_BITS > CHANNEL_BITS) ? Q_BITS : CHANNEL_BITS;
   localparam int NUM_BITS  = CHANNEL_BITS + DIV_STEPS;

   localparam int HUE_CALC_BITS = $clog2(FULL_CIRCLE);
   localparam logic [HUE_CALC_BITS-1:0] HUE_FULL   = HUE_CALC_BITS'(FULL_CIRCLE);
   localparam logic [HUE_CALC_BITS-1:0] HUE_GREEN  = HUE_CALC_BITS'(2 * SIXTH);
   localparam logic [HUE_CALC_BITS-1:0] HUE_BLUE   = HUE_CALC_BITS'(4 * SIXTH);

   // which channel holds the maximum (red before green before blue on ties)
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // restoring divider state: running remainder and shifting dividend/quotient bits
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] den;
      logic [CHANNEL_BITS-1:0] rem;
      logic [DIV_STEPS-1:0]    acc;
   } div_type;

   typedef struct packed {
      sector_type              sector;
      logic                    neg;
      logic                    undef;
      logic [CHANNEL_BITS-1:0] value;
   } meta_type;

   typedef struct packed {
      meta_type meta;
      div_type  sat_div;
      div_type  hue_div;
   } stage_type;

endpackage

[rtl/rgbhsv_pixel_if.sv]
`timescale 1ns / 1ps
// rgbhsv_pixel_if: valid/ready channel carrying one rgb pixel word
// depends on rgbhsv_pkg for the field widths

interface rgbhsv_pixel_if;
   logic                             valid;
   logic                             ready;
   logic [rgbhsv_pkg::RGB_BITS-1:0]  red;
   logic [rgbhsv_pkg::RGB_BITS-1:0]  green;
   logic [rgbhsv_pkg::RGB_BITS-1:0]  blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/rgbhsv_hsv_if.sv]
`timescale 1ns / 1ps
// rgbhsv_hsv_if: valid/ready channel carrying one hsv result word
// depends on rgbhsv_pkg for the field widths

interface rgbhsv_hsv_if;
   logic                             valid;
   logic                             ready;
   logic [rgbhsv_pkg::HUE_BITS-1:0]  hue;
   logic [rgbhsv_pkg::SAT_BITS-1:0]  saturation;
   logic [rgbhsv_pkg::VAL_BITS-1:0]  brightness;
   logic                             hue_undefined;

   modport source (output valid, output hue, output saturation, output brightness,
                   output hue_undefined, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   input hue_undefined, output ready);
endinterface

[rtl/rgbhsv_div_stage.sv]
`timescale 1ns / 1ps
// rgbhsv_div_stage: one registered stage of the two restoring dividers, one quotient bit each
// depends on rgbhsv_pkg for the stage word type

module rgbhsv_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rgbhsv_pkg::stage_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rgbhsv_pkg::stage_type out_data
);
   import rgbhsv_pkg::*;

   function automatic div_type div_step(input div_type d);
      div_type                 res;
      logic [CHANNEL_BITS:0]   shifted;
      logic [CHANNEL_BITS:0]   diff;
      logic                    take;
      shifted = {d.rem, d.acc[DIV_STEPS-1]};
      diff    = shifted - {1'b0, d.den};
      take    = (shifted >= {1'b0, d.den});
      res.den = d.den;
      res.rem = take ? diff[CHANNEL_BITS-1:0] : shifted[CHANNEL_BITS-1:0];
      res.acc = {d.acc[DIV_STEPS-2:0], take};
      return res;
   endfunction

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.meta    = in_data.meta;
      data_in.sat_div = div_step(in_data.sat_div);
      data_in.hue_div = div_step(in_data.hue_div);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/rgb_to_hsv_converter_unit.sv]
`timescale 1ns / 1ps
// rgb_to_hsv_converter_unit: top level of the pipelined rgb to hsv converter
// depends on rgbhsv_pkg, rgbhsv_pixel_if, rgbhsv_hsv_if and rgbhsv_div_stage
//
// usage
//   req_if takes one rgb pixel word per valid/ready handshake, rsp_if returns one
//   hsv word per pixel, in order. value is the largest channel, saturation is
//   floor(delta*255/max), hue is in 1/64 degree. grey and black pixels give hue 0,
//   saturation 0 and hue_undefined set
//   throughput: one word per clock cycle, sustained while rsp_if.ready stays high
//   from acceptance to rsp_if.valid a word passes one front stage (max/min/delta,
//   numerators), then a restoring divider that retires one quotient bit per stage
//   for saturation and hue side by side, then the hue offset/wrap stage that feeds
//   the output register
//   every stage carries its own valid bit and loads whenever it is empty or its
//   successor moves, so bubbles collapse and req_if.ready stays high while a
//   stalled result waits, until every stage holds a word
//   when rsp_if.ready is low the output register holds its word unchanged
//   synchronous reset empties all stages; no word in flight survives it
//   there are no configuration registers and no other state

module rgb_to_hsv_converter_unit (
   input  logic          clock,
   input  logic          reset,
   rgbhsv_pixel_if.sink  req_if,
   rgbhsv_hsv_if.source  rsp_if
);
   import rgbhsv_pkg::*;

   // ---------------------------------------------------------------- front stage
   logic      front_valid_ff;
   logic      front_ready;
   stage_type front_ff;
   stage_type front_in;

   // divider chain, index 0 is the front stage output
   stage_type div_data  [DIV_STEPS+1];
   logic      div_valid [DIV_STEPS+1];
   logic      div_ready [DIV_STEPS+1];

   // output register
   logic                      rsp_valid_ff;
   logic [HUE_BITS-1:0]       hue_ff;
   logic [SAT_BITS-1:0]       sat_ff;
   logic [VAL_BITS-1:0]       val_ff;
   logic                      undef_ff;
   logic                      out_ready;
   logic [HUE_BITS-1:0]       hue_in;
   logic [SAT_BITS-1:0]       sat_in;
   logic [VAL_BITS-1:0]       val_in;
   logic                      undef_in;

   // front: max, min, delta, sector and the two numerators
   always_comb begin
      logic [CHANNEL_BITS-1:0] red_ch;
      logic [CHANNEL_BITS-1:0] grn_ch;
      logic [CHANNEL_BITS-1:0] blu_ch;
      logic [CHANNEL_BITS-1:0] mx;
      logic [CHANNEL_BITS-1:0] mn;
      logic [CHANNEL_BITS-1:0] delta;
      logic [CHANNEL_BITS-1:0] op_a;
      logic [CHANNEL_BITS-1:0] op_b;
      logic [CHANNEL_BITS-1:0] diff;
      logic [NUM_BITS-1:0]     sat_num;
      logic [NUM_BITS-1:0]     hue_num;
      logic                    undef;
      sector_type              sector;

      red_ch = CHANNEL_BITS'(req_if.red);
      grn_ch = CHANNEL_BITS'(req_if.green);
      blu_ch = CHANNEL_BITS'(req_if.blue);

      mx = red_ch;
      if (grn_ch > mx) mx = grn_ch;
      if (blu_ch > mx) mx = blu_ch;
      mn = red_ch;
      if (grn_ch < mn) mn = grn_ch;
      if (blu_ch < mn) mn = blu_ch;
      delta = mx - mn;
      // black implies delta zero too
      undef = (delta == '0);

      // red wins ties, then green
      if (red_ch == mx) begin
         sector = SECT_RED;
         op_a   = grn_ch;
         op_b   = blu_ch;
      end else if (grn_ch == mx) begin
         sector = SECT_GREEN;
         op_a   = blu_ch;
         op_b   = red_ch;
      end else begin
         sector = SECT_BLUE;
         op_a   = red_ch;
         op_b   = grn_ch;
      end
      diff = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

      // constant multiplies, both quotients fit in DIV_STEPS bits
      sat_num = NUM_BITS'(delta) * NUM_BITS'(CHAN_MAX);
      hue_num = NUM_BITS'(diff) * NUM_BITS'(SIXTH);

      front_in.meta.sector = sector;
      front_in.meta.neg    = (op_a < op_b);
      front_in.meta.undef  = undef;
      front_in.meta.value  = mx;

      // grey or black: divide by one so the datapath stays defined
      front_in.sat_div.den = undef ? CHANNEL_BITS'(1) : mx;
      front_in.sat_div.rem = sat_num[NUM_BITS-1:DIV_STEPS];
      front_in.sat_div.acc = sat_num[DIV_STEPS-1:0];
      front_in.hue_div.den = undef ? CHANNEL_BITS'(1) : delta;
      front_in.hue_div.rem = hue_num[NUM_BITS-1:DIV_STEPS];
      front_in.hue_div.acc = hue_num[DIV_STEPS-1:0];
   end

   assign front_ready  = !front_valid_ff || div_ready[0];
   assign req_if.ready = front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_ready) begin
         front_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_ready && req_if.valid) begin
         front_ff <= front_in;
      end
   end

   // ---------------------------------------------------------------- divider pipeline
   assign div_data[0]  = front_ff;
   assign div_valid[0] = front_valid_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      rgbhsv_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_ready  (div_ready[i]),
         .in_data   (div_data[i]),
         .out_valid (div_valid[i+1]),
         .out_ready (div_ready[i+1]),
         .out_data  (div_data[i+1])
      );
   end

   // ---------------------------------------------------------------- hue offset and wrap
   always_comb begin
      logic [HUE_CALC_BITS-1:0] hq;
      logic [HUE_CALC_BITS-1:0] hue_calc;
      meta_type                 meta;

      meta = div_data[DIV_STEPS].meta;
      hq   = HUE_CALC_BITS'(div_data[DIV_STEPS].hue_div.acc);

      case (meta.sector)
         SECT_RED: begin
            // negative hue wraps once around the circle, minus zero stays zero
            hue_calc = (meta.neg && hq != '0) ? (HUE_FULL - hq) : hq;
         end
         SECT_GREEN: begin
            hue_calc = meta.neg ? (HUE_GREEN - hq) : (HUE_GREEN + hq);
         end
         SECT_BLUE: begin
            hue_calc = meta.neg ? (HUE_BLUE - hq) : (HUE_BLUE + hq);
         end
         default: begin
            hue_calc = '0;
         end
      endcase

      undef_in = meta.undef;
      hue_in   = meta.undef ? '0 : HUE_BITS'(hue_calc);
      sat_in   = meta.undef ? '0
                            : SAT_BITS'(div_data[DIV_STEPS].sat_div.acc[CHANNEL_BITS-1:0]);
      val_in   = VAL_BITS'(meta.value);
   end

   // ---------------------------------------------------------------- output register
   assign out_ready              = !rsp_valid_ff || rsp_if.ready;
   assign div_ready[DIV_STEPS]   = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_valid[DIV_STEPS]) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         val_ff   <= val_in;
         undef_ff <= undef_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.hue           = hue_ff;
   assign rsp_if.saturation    = sat_ff;
   assign rsp_if.brightness    = val_ff;
   assign rsp_if.hue_undefined = undef_ff;

endmodule

[rtl/rgbhsv_checker.sv]
`timescale 1ns / 1ps
// rgbhsv_checker: port-level assertions for the rgb to hsv converter, bound to the top level
// depends on rgbhsv_pkg and rgb_to_hsv_converter_unit

module rgbhsv_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rgbhsv_pkg::HUE_BITS-1:0]  rsp_hue,
   input logic [rgbhsv_pkg::SAT_BITS-1:0]  rsp_saturation,
   input logic [rgbhsv_pkg::VAL_BITS-1:0]  rsp_brightness,
   input logic                             rsp_hue_undefined
);
   import rgbhsv_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue) &&
      $stable(rsp_saturation) && $stable(rsp_brightness) && $stable(rsp_hue_undefined))
      else $error("rsp word changed while stalled");

   // reset leaves no word in flight
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // grey or black gives zero hue and zero saturation
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hue_undefined |-> rsp_hue == '0 && rsp_saturation == '0)
      else $error("undefined hue with nonzero hue or saturation");

   // a colored pixel has nonzero value and saturation and hue inside the circle
   a_defined_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hue_undefined |->
      rsp_brightness != '0 && rsp_saturation != '0 &&
      rsp_hue < HUE_BITS'(FULL_CIRCLE))
      else $error("defined hue word out of range");

   // with the output register free to move, the whole chain moves and the input is ready
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("req ready low while the output can move");

endmodule

bind rgb_to_hsv_converter_unit rgbhsv_checker u_rgbhsv_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_hue           (rsp_if.hue),
   .rsp_saturation    (rsp_if.saturation),
   .rsp_brightness    (rsp_if.brightness),
   .rsp_hue_undefined (rsp_if.hue_undefined)
);
